@@ src/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// Positional list engine package
// Word types, operation and status codes, and cell control shared by the
// list engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  // Default number of list cells
  localparam int DEPTH_DEFAULT = 64;
  // Cells per priority group in the locate search
  localparam int GROUP_SIZE = 8;

  // Operation codes
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;
  localparam logic [1:0] FUNC_LOCATE = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_BAD_POS   = 2'd1;
  localparam logic [1:0] STATUS_LIST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [6:0]         position;
    logic signed [31:0] value;
  } ple_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [5:0] found_index;
    logic [6:0] list_length;
  } ple_result_t;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic ins;   // insert: open a gap at the position
    logic del;   // delete: close the gap at the position
  } ple_shift_t;

endpackage

`default_nettype wire

@@ src/ple_cell.sv @@
// ----------------------------------------------------------------------------
// List cell
// Holds one entry, takes the insert value or its lower or upper neighbor on a shift, and
// registers whether its entry matches the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell
  import ple_pkg::*;
#(
  parameter int PW  = 8,
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire ple_shift_t         shift,
  input  wire logic [PW-1:0]      pos_m1,
  input  wire logic signed [31:0] ins_value,
  input  wire logic signed [31:0] lower,
  input  wire logic signed [31:0] upper,
  input  wire logic signed [31:0] key,
  input  wire logic               live,
  output logic signed [31:0]      entry,
  output logic                    match
);

  logic [PW-1:0] my_idx;
  logic          at_pos;
  logic          above_pos;

  assign my_idx    = PW'(IDX);
  assign at_pos    = (my_idx == pos_m1);
  assign above_pos = (my_idx > pos_m1);

  always_ff @(posedge clk) begin
    if (shift.ins) begin
      if (at_pos) begin
        entry <= ins_value;
      end else if (above_pos) begin
        entry <= lower;
      end
    end else if (shift.del) begin
      // pull from above at and beyond the deleted slot
      if (at_pos || above_pos) begin
        entry <= upper;
      end
    end
    match <= live && (entry == key);
  end

endmodule

`default_nettype wire

@@ src/ple_group.sv @@
// ----------------------------------------------------------------------------
// Priority group
// Picks the lowest matching cell within one group and registers the pick.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_group
  import ple_pkg::*;
#(
  parameter int GW = GROUP_SIZE
) (
  input  wire logic                    clk,
  input  wire logic [GW-1:0]           hits,
  output logic                         any,
  output logic [$clog2(GW)-1:0]        idx
);

  logic [$clog2(GW)-1:0] idx_next;

  always_comb begin
    idx_next = '0;
    // scan from the top so the lowest hit wins
    for (int i = GW - 1; i >= 0; i--) begin
      if (hits[i]) begin
        idx_next = ($clog2(GW))'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    any <= |hits;
    idx <= idx_next;
  end

endmodule

`default_nettype wire

@@ src/positional_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit entries in a row of cells with insert,
// delete, clear and locate operations.
//
//   channel   ports                  direction  handshake
//   command   start, busy, cmd       in         taken when start && !busy
//   result    done, result           out        one-cycle strobe, no stall
//
// Insert and delete shift the cells in parallel at the accept edge, and clear
// only empties the list; the result strobes the next cycle and busy stays low,
// so these run one word per cycle. Locate holds busy high through its steps:
// cell compare, group priority pick, final group pick.
// Reset empties the list; cell contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire ple_cmd_t    cmd,
  output logic             done,
  output ple_result_t      result
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PW  = ((CW > 7) ? CW : 7) + 1;
  localparam int GW  = GROUP_SIZE;
  localparam int GIW = $clog2(GW);
  localparam int NG  = (DEPTH + GW - 1) / GW;
  localparam int NGW = (NG > 1) ? $clog2(NG) : 1;

  typedef enum logic [1:0] {IDLE, CMP, GRP, PICK} phase_t;

  phase_t              phase;
  logic [CW-1:0]       count;
  logic signed [31:0]  key;

  logic                accept;
  logic [PW-1:0]       pos_x;
  logic [PW-1:0]       cnt_x;
  logic [PW-1:0]       pos_m1;
  logic                ins_ok;
  logic                del_ok;
  logic                full;
  ple_shift_t          shift;

  logic signed [31:0]  entry [DEPTH];
  logic [NG*GW-1:0]    hits;
  logic [NG-1:0]       grp_any;
  logic [GIW-1:0]      grp_idx [NG];

  logic                pick_any;
  logic [NGW-1:0]      pick_grp;
  logic [GIW-1:0]      pick_loc;

  assign accept = start && !busy;
  assign busy   = (phase != IDLE);
  assign pos_x  = PW'(cmd.position);
  assign cnt_x  = PW'(count);
  assign pos_m1 = pos_x - PW'(1);
  assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + PW'(1));
  assign del_ok = (pos_x != '0) && (pos_x <= cnt_x);
  assign full   = (count == CW'(DEPTH));

  assign shift.ins = accept && (cmd.func == FUNC_INSERT) && ins_ok && !full;
  assign shift.del = accept && (cmd.func == FUNC_DELETE) && del_ok;

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    if (i == 0) begin : g_first
      assign lower = cmd.value;
    end else begin : g_mid
      assign lower = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = entry[i];
    end else begin : g_up
      assign upper = entry[i+1];
    end
    ple_cell #(
      .PW  (PW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .shift     (shift),
      .pos_m1    (pos_m1),
      .ins_value (cmd.value),
      .lower     (lower),
      .upper     (upper),
      .key       (key),
      .live      (PW'(i) < cnt_x),
      .entry     (entry[i]),
      .match     (hits[i])
    );
  end

  // Pad the last group
  if (NG * GW > DEPTH) begin : g_pad
    assign hits[NG*GW-1:DEPTH] = '0;
  end

  // Priority groups
  for (genvar g = 0; g < NG; g++) begin : g_grp
    ple_group #(
      .GW (GW)
    ) u_group (
      .clk  (clk),
      .hits (hits[g*GW +: GW]),
      .any  (grp_any[g]),
      .idx  (grp_idx[g])
    );
  end

  always_comb begin
    pick_grp = '0;
    pick_loc = '0;
    pick_any = |grp_any;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        pick_grp = NGW'(g);
        pick_loc = grp_idx[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        IDLE: begin
          if (accept) begin
            result.found       <= 1'b0;
            result.found_index <= '0;
            result.status      <= STATUS_DONE;
            result.list_length <= 7'(count);
            case (cmd.func)
              FUNC_CLEAR: begin
                count              <= '0;
                result.list_length <= '0;
                done               <= 1'b1;
              end
              FUNC_INSERT: begin
                if (!ins_ok) begin
                  result.status <= STATUS_BAD_POS;
                end else if (full) begin
                  result.status <= STATUS_LIST_FULL;
                end else begin
                  count              <= count + CW'(1);
                  result.list_length <= 7'(count + CW'(1));
                end
                done <= 1'b1;
              end
              FUNC_DELETE: begin
                if (!del_ok) begin
                  result.status <= STATUS_BAD_POS;
                end else begin
                  count              <= count - CW'(1);
                  result.list_length <= 7'(count - CW'(1));
                end
                done <= 1'b1;
              end
              default: begin
                key   <= cmd.value;
                phase <= CMP;
              end
            endcase
          end
        end
        CMP: begin
          phase <= GRP;
        end
        GRP: begin
          phase <= PICK;
        end
        PICK: begin
          result.status      <= STATUS_DONE;
          result.found       <= pick_any;
          result.found_index <= pick_any ? 6'({pick_grp, pick_loc}) : 6'(0);
          result.list_length <= 7'(count);
          done               <= 1'b1;
          phase              <= IDLE;
        end
        default: begin
          phase <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
